// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the stepper valve driver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SVPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define SVPD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/svpd_pkg.sv -----
// Types, codes and constants of the stepper valve position driver.
package svpd_pkg;

    localparam int unsigned PERIOD_W   = 24;
    localparam int unsigned AMOUNT_W   = 16;
    localparam int unsigned COIL_W     = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;

    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 24'd213336;
    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 24'd106668;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_RUN  = 2'd1,
        ACT_SET  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    // Register index as decoded from the word address.
    typedef enum logic {
        REG_SLOW_PERIOD = 1'b0,
        REG_FAST_PERIOD = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [PERIOD_W-1:0] slow_period;
        logic [PERIOD_W-1:0] fast_period;
    } t_cfg;

    typedef struct packed {
        t_action                    action;
        logic signed [AMOUNT_W-1:0] amount;
        logic                       fast;
    } t_item;

    typedef struct packed {
        logic [COIL_W-1:0]          coils;
        logic                       awake;
        logic signed [AMOUNT_W-1:0] position;
        logic                       stepped;
    } t_result;

    // Full-step phase pattern, coil order A1, A2, B1, B2 from bit 0 up.
    function automatic logic [COIL_W-1:0] phase_coils(input logic [1:0] phase);
        logic [COIL_W-1:0] c;
        case (phase)
            2'd0:    c = 4'b0001;
            2'd1:    c = 4'b0100;
            2'd2:    c = 4'b0010;
            2'd3:    c = 4'b1000;
            default: c = 4'b0000;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/svpd_regs.sv -----
// Configuration registers of the stepper valve driver on an APB-style port.
module svpd_regs
    import svpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [PERIOD_W-1:0] r_slow;
    logic [PERIOD_W-1:0] r_fast;
    logic                w_wr;
    t_reg_idx            w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow <= SLOW_PERIOD_RST;
            r_fast <= FAST_PERIOD_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_SLOW_PERIOD: r_slow <= pwdata[PERIOD_W-1:0];
                REG_FAST_PERIOD: r_fast <= pwdata[PERIOD_W-1:0];
                default:         r_slow <= r_slow;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SLOW_PERIOD: prdata = CFG_DATA_W'(r_slow);
            REG_FAST_PERIOD: prdata = CFG_DATA_W'(r_fast);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = '{slow_period: r_slow, fast_period: r_fast};

endmodule

// ----- hw/rtl/svpd_core.sv -----
// Position, target, divider and coil state with the per-item step logic.
`include "assert_macros.svh"

module svpd_core
    import svpd_pkg::*;
#(
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int unsigned SW = ((POSITION_BITS > AMOUNT_W) ? POSITION_BITS : AMOUNT_W) + 1;
    localparam logic signed [SW-1:0] PMAX = SW'((64'sd1 <<< (POSITION_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);

    logic signed [POSITION_BITS-1:0] r_pos, n_pos;
    logic signed [POSITION_BITS-1:0] r_tgt, n_tgt;
    logic [PERIOD_W-1:0]             r_per, n_per;
    logic [PERIOD_W-1:0]             r_div, n_div;
    logic [COIL_W-1:0]               r_coil, n_coil;
    logic                            r_awake, n_awake;

    logic [PERIOD_W:0]               w_per_eff;
    logic [PERIOD_W:0]               w_div_inc;
    logic                            w_fire;
    logic                            w_stepped;
    logic signed [SW-1:0]            w_pos_ext;
    logic signed [SW-1:0]            w_amt_ext;
    logic signed [SW-1:0]            w_sum;
    logic signed [SW-1:0]            w_sum_clamp;
    logic signed [SW-1:0]            w_set_clamp;
    logic signed [SW-1:0]            w_npos_ext;

    assign w_per_eff = (r_per == '0) ? (PERIOD_W+1)'(1) : {1'b0, r_per};
    assign w_div_inc = {1'b0, r_div} + (PERIOD_W+1)'(1);
    assign w_fire    = (w_div_inc >= w_per_eff);

    assign w_pos_ext = SW'(r_pos);
    assign w_amt_ext = SW'(i_item.amount);
    assign w_sum     = w_pos_ext + w_amt_ext;

    // Saturate both the run target and the set value to the position range.
    assign w_sum_clamp = (w_sum > PMAX) ? PMAX : ((w_sum < PMIN) ? PMIN : w_sum);
    assign w_set_clamp = (w_amt_ext > PMAX) ? PMAX :
                         ((w_amt_ext < PMIN) ? PMIN : w_amt_ext);

    always_comb begin
        n_pos     = r_pos;
        n_tgt     = r_tgt;
        n_per     = r_per;
        n_div     = r_div;
        n_coil    = r_coil;
        n_awake   = r_awake;
        w_stepped = 1'b0;
        case (i_item.action)
            ACT_TICK: begin
                if (w_fire) begin
                    w_stepped = 1'b1;
                    n_div     = '0;
                    n_coil    = phase_coils(r_pos[1:0]);
                    n_awake   = (r_pos != r_tgt);
                    if (r_pos < r_tgt) begin
                        n_pos = r_pos + POSITION_BITS'(1);
                    end else if (r_pos > r_tgt) begin
                        n_pos = r_pos - POSITION_BITS'(1);
                    end else begin
                        n_per = PERIOD_W'(1);
                    end
                end else begin
                    n_div = w_div_inc[PERIOD_W-1:0];
                end
            end
            ACT_RUN: begin
                n_tgt = w_sum_clamp[POSITION_BITS-1:0];
                n_per = i_item.fast ? i_cfg.fast_period : i_cfg.slow_period;
                n_div = '0;
            end
            ACT_SET: begin
                n_pos = w_set_clamp[POSITION_BITS-1:0];
                n_tgt = w_set_clamp[POSITION_BITS-1:0];
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_tgt   <= '0;
            r_per   <= PERIOD_W'(1);
            r_div   <= '0;
            r_coil  <= '0;
            r_awake <= 1'b0;
        end else if (i_go) begin
            r_pos   <= n_pos;
            r_tgt   <= n_tgt;
            r_per   <= n_per;
            r_div   <= n_div;
            r_coil  <= n_coil;
            r_awake <= n_awake;
        end
    end

    assign w_npos_ext = SW'(n_pos);

    assign o_res = '{coils:    n_coil,
                     awake:    n_awake,
                     position: w_npos_ext[AMOUNT_W-1:0],
                     stepped:  w_stepped};

    `SVPD_ASSERT(a_div_below_period, i_clk, i_rst_n, ({1'b0, r_div} < w_per_eff),
        "divider count reached the step period")
    `SVPD_ASSERT_NEXT(a_step_moves, i_clk, i_rst_n,
        (i_go && (i_item.action == ACT_TICK) && w_fire && (r_pos != r_tgt)),
        (r_pos != $past(r_pos)), "step event toward target left position unchanged")
    `SVPD_ASSERT_NEXT(a_awake_on_step, i_clk, i_rst_n,
        (i_go && (i_item.action == ACT_TICK) && w_fire),
        (r_awake == ($past(r_pos) != $past(r_tgt))), "awake does not match position vs target")

endmodule

// ----- hw/rtl/stepper_valve_position_driver_core.sv -----
// Top level of the stepper valve position driver: stream ports, item register, result register.
//
// Channel   Dir  Handshake                       Payload (low bit up)
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: amount[15:0], fast[16], zero [23:17]
//                                                tuser: action[1:0]
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: coils[3:0], awake[4], position[20:5],
//                                                       stepped[21], zero [23:22]
// apb       in   psel, penable, pwrite, pready   slow_period at 0x0, fast_period at 0x4
//
// One item per cycle while results are taken; each accepted item passes through the item
// register, then the state update and the result register, which presents its result.
// Per item the core does the tick divider compare and one-step position move, or the run target or set value.
// Reset is synchronous, active low: position and target 0, period 1, coils and awake off.
// A stalled result register holds; the item register still takes one more item, then
// tready drops until the result is taken.
`include "assert_macros.svh"

module stepper_valve_position_driver_core
    import svpd_pkg::*;
#(
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // amount[15:0], fast[16]
    input  logic [1:0]            s_axis_tuser,  // action[1:0]
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,  // coils[3:0], awake[4], position[20:5], stepped[21]
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    w_out_free;
    logic    w_adv;
    t_result w_res;
    t_cfg    w_cfg;

    svpd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Result register is free when empty or being drained this cycle.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // Hold the accepted item until the core can take it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= '{action: t_action'(s_axis_tuser),
                      amount: s_axis_tdata[AMOUNT_W-1:0],
                      fast:   s_axis_tdata[AMOUNT_W]};
        end
    end

    svpd_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_adv),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Load the result as the core advances; drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.stepped, r_out.position, r_out.awake, r_out.coils};

    `SVPD_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, (r_in_valid && !w_adv), r_in_valid,
        "pending item lost from the item register")
    `SVPD_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, w_adv, r_out_valid,
        "core advanced without a result in the result register")

endmodule

// ----- tb/svpd_motion_checker.sv -----
`timescale 1ns / 100ps
// Checker for the stepper valve driver: mirrors its state, predicts each result item and compares.
module svpd_motion_checker
    import svpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_tvalid,
    input  logic                  i_in_tready,
    input  logic [23:0]           i_in_tdata,   // amount[15:0], fast[16]
    input  logic [1:0]            i_in_tuser,   // action[1:0]
    input  logic                  i_out_tvalid,
    input  logic                  i_out_tready,
    input  logic [23:0]           i_out_tdata,  // coils[3:0], awake[4], position[20:5], stepped[21]
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    t_cfg                       cfg_q;
    logic signed [AMOUNT_W-1:0] pos_q;
    logic signed [AMOUNT_W-1:0] tgt_q;
    logic [PERIOD_W-1:0]        period_q;
    logic [PERIOD_W-1:0]        div_q;
    logic [COIL_W-1:0]          coil_q;
    logic                       awake_q;
    t_result                    due_results[$];
    int                         fails = 0;

    // Clamp a run target to the signed position range.
    function automatic logic signed [AMOUNT_W-1:0] saturate(input int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[AMOUNT_W-1:0];
    endfunction

    // Apply one item to the mirrored state and return the result item it produces.
    task automatic drive_step(input t_item it, output t_result res);
        logic [PERIOD_W-1:0] per;
        logic [PERIOD_W:0]   next;
        logic                fired;
        fired = 1'b0;
        case (it.action)
            ACT_TICK: begin
                // a zero period acts as one tick
                per  = (period_q == '0) ? PERIOD_W'(1) : period_q;
                next = {1'b0, div_q} + 1'b1;
                if (next < {1'b0, per}) begin
                    div_q = next[PERIOD_W-1:0];
                end else begin
                    fired = 1'b1;
                    div_q = '0;
                    case (pos_q[1:0])
                        2'd0:    coil_q = 4'b0001;
                        2'd1:    coil_q = 4'b0100;
                        2'd2:    coil_q = 4'b0010;
                        default: coil_q = 4'b1000;
                    endcase
                    awake_q = (pos_q != tgt_q);
                    if (pos_q < tgt_q) begin
                        pos_q = pos_q + 16'sd1;
                    end else if (pos_q > tgt_q) begin
                        pos_q = pos_q - 16'sd1;
                    end else begin
                        period_q = PERIOD_W'(1);
                    end
                end
            end
            ACT_RUN: begin
                tgt_q    = saturate(int'(pos_q) + int'(it.amount));
                period_q = it.fast ? cfg_q.fast_period : cfg_q.slow_period;
                div_q    = '0;
            end
            ACT_SET: begin
                pos_q = it.amount;
                tgt_q = it.amount;
            end
            default: begin
            end
        endcase
        res.coils    = coil_q;
        res.awake    = awake_q;
        res.position = pos_q;
        res.stepped  = fired;
    endtask

    always @(posedge i_clk) begin : monitor
        t_item   it;
        t_result res;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            cfg_q.slow_period = SLOW_PERIOD_RST;
            cfg_q.fast_period = FAST_PERIOD_RST;
            pos_q    = '0;
            tgt_q    = '0;
            period_q = PERIOD_W'(1);
            div_q    = '0;
            coil_q   = '0;
            awake_q  = 1'b0;
            due_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    REG_SLOW_PERIOD: cfg_q.slow_period = i_pwdata[PERIOD_W-1:0];
                    REG_FAST_PERIOD: cfg_q.fast_period = i_pwdata[PERIOD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_out_tvalid && i_out_tready) begin
                got.coils    = i_out_tdata[3:0];
                got.awake    = i_out_tdata[4];
                got.position = i_out_tdata[20:5];
                got.stepped  = i_out_tdata[21];
                if (due_results.size() == 0) begin
                    $error("result item with nothing expected: tdata %h", i_out_tdata);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    if (got.coils !== want.coils) begin
                        $error("coils: expected %h, got %h", want.coils, got.coils);
                        fails++;
                    end
                    if (got.awake !== want.awake) begin
                        $error("awake: expected %b, got %b", want.awake, got.awake);
                        fails++;
                    end
                    if (got.position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, got.position);
                        fails++;
                    end
                    if (got.stepped !== want.stepped) begin
                        $error("stepped: expected %b, got %b", want.stepped, got.stepped);
                        fails++;
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                it.action = t_action'(i_in_tuser);
                it.amount = i_in_tdata[15:0];
                it.fast   = i_in_tdata[16];
                drive_step(it, res);
                due_results.push_back(res);
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_results.size();
    end

endmodule

// ----- tb/tb_stepper_valve_position_driver_core.sv -----
`timescale 1ns / 100ps
// Testbench top for the stepper valve driver: clock, reset, stimulus, stalls and verdict.
module tb_stepper_valve_position_driver_core;
    import svpd_pkg::*;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;   // amount[15:0], fast[16]
    logic [1:0]            s_axis_tuser  = '0;   // action[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;         // coils[3:0], awake[4], position[20:5], stepped[21]
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;
    int                    idle_pct   = 0;
    int                    stall_pct  = 0;
    bit                    hold_req   = 1'b0;
    int                    hold_left  = 0;
    int                    items_sent = 0;
    logic [PERIOD_W-1:0]   slow_now   = SLOW_PERIOD_RST;
    logic [PERIOD_W-1:0]   fast_now   = FAST_PERIOD_RST;

    always #4 i_clk = ~i_clk;

    stepper_valve_position_driver_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    svpd_motion_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random stalls, plus a long hold-off on request to back up the pipeline.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 300;
            hold_req  = 1'b0;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one item, idling first at random, and return at the edge that accepts it.
    task automatic send_item(input t_action act, input logic signed [15:0] amt, input logic fst);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, fst, amt};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (act != ACT_NONE) items_sent++;
    endtask

    // Drop valid and hold until every result item is back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_period(input t_reg_idx idx, input logic [PERIOD_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SLOW_PERIOD) slow_now = val;
        else fast_now = val;
    endtask

    // Reprogram both periods with the block idle.
    task automatic set_periods(input logic [PERIOD_W-1:0] slow, input logic [PERIOD_W-1:0] fst);
        wait_drained();
        write_period(REG_SLOW_PERIOD, slow);
        write_period(REG_FAST_PERIOD, fst);
    endtask

    // One move: optional set, a run, enough ticks to finish it (or fewer), and some noise.
    task automatic run_motion();
        logic signed [15:0] amt;
        logic               fst;
        longint             span;
        int                 n;
        if ($urandom_range(3) == 0) send_item(ACT_SET, 16'($urandom), 1'($urandom));
        if ($urandom_range(15) == 0) amt = 16'($urandom);
        else amt = 16'(int'($urandom_range(40)) - 20);
        fst = 1'($urandom);
        send_item(ACT_RUN, amt, fst);
        span = (amt < 0 ? -longint'(amt) : longint'(amt))
               * longint'(fst ? fast_now : slow_now) + 3;
        if (span > 48) span = 48;
        n = ($urandom_range(3) == 0) ? int'($urandom_range(int'(span))) : int'(span);
        repeat (n) send_item(ACT_TICK, 16'($urandom), 1'($urandom));
        if ($urandom_range(9) == 0)
            send_item(t_action'($urandom_range(3)), 16'($urandom), 1'($urandom));
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        int start;
        start     = items_sent;
        idle_pct  = idle;
        stall_pct = stall;
        while (items_sent - start < count) run_motion();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset periods, idle-period tick, unused code, range extremes.
        send_item(ACT_TICK, 16'sd0, 1'b0);
        send_item(ACT_NONE, 16'shffff, 1'b1);
        send_item(ACT_SET, 16'sh7fff, 1'b0);
        send_item(ACT_RUN, 16'sd100, 1'b1);      // target saturates high
        send_item(ACT_TICK, 16'sd0, 1'b0);
        send_item(ACT_SET, 16'sh8000, 1'b1);
        send_item(ACT_RUN, -16'sd1, 1'b0);       // target saturates low
        send_item(ACT_TICK, 16'shffff, 1'b1);

        // Zero slow period behaves as one tick; fast period two shows divider restart.
        set_periods(24'd0, 24'd2);
        send_item(ACT_RUN, 16'sd3, 1'b0);
        repeat (4) send_item(ACT_TICK, 16'sd0, 1'b0);
        send_item(ACT_RUN, 16'sd2, 1'b1);
        send_item(ACT_TICK, 16'sd0, 1'b0);
        send_item(ACT_RUN, 16'sd2, 1'b1);        // restart the divider mid-period
        send_item(ACT_TICK, 16'sd0, 1'b0);
        send_item(ACT_TICK, 16'sd0, 1'b0);
        send_item(ACT_SET, 16'sd0, 1'b1);        // fast ignored on set
        send_item(ACT_RUN, 16'sh7fff, 1'b0);
        send_item(ACT_TICK, 16'sd0, 1'b0);
        send_item(ACT_TICK, 16'sd0, 1'b0);
        send_item(ACT_RUN, 16'sh8000, 1'b1);
        send_item(ACT_TICK, 16'sd0, 1'b0);
        send_item(ACT_SET, 16'sd5, 1'b0);
        send_item(ACT_TICK, 16'sd0, 1'b0);

        // No idling; back up the pipeline with a long receiver hold-off midway.
        set_periods(24'd1, 24'd2);
        run_phase(0, 0, 40);
        hold_req = 1'b1;
        run_phase(0, 0, 85);

        // Sender idles; pause once until everything is back.
        set_periods(24'hffffff, 24'd1);
        run_phase(73, 0, 60);
        wait_drained();
        run_phase(73, 0, 65);

        // Receiver stalls.
        set_periods(24'd2, 24'hffffff);
        run_phase(0, 73, 125);

        // Both sides idle.
        set_periods(24'd3, 24'd1);
        run_phase(34, 34, 125);

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop if the run hangs.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
